FILE: src/rpe_pkg.sv
// rpe_pkg: shared types and constants of the run-length packet encoder.
// No dependencies; the core, queue, front, back and bench use it by scoped names.
package rpe_pkg;

  // Width of a packet count as carried between front and back.
  localparam int unsigned CNT_BITS = 6;
  // Bit 7 of a header marks a run packet.
  localparam logic [7:0] RUN_FLAG = 8'h80;
  // Entries of the command queue between front and back.
  localparam int unsigned CMD_DEPTH = 4;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_header;
    logic       last_of_item;
  } out_item_t;

  // One packet to emit: header, nbuf bytes from the literal buffer bank,
  // then an optional trailing byte (the run byte or the final literal).
  typedef struct packed {
    logic [7:0]          hdr;
    logic [CNT_BITS-1:0] nbuf;
    logic                tail;
    logic [7:0]          data;
    logic                bank;
    logic                lit;
    logic                last;
  } pkt_cmd_t;

endpackage

FILE: src/rpe_stream_if.sv
// rpe_stream_if: valid/ready channel with a typed payload.
// Depends on nothing; payload types come from rpe_pkg at instantiation.
interface rpe_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: src/rle_packet_encoder_core.sv
// rle_packet_encoder_core: run-length packet encoder, one byte in per transaction.
// An accepted byte's packet commands are registered in the command queue, and each
// packet byte in the back end's output register. One output byte per cycle while
// commands wait and the downstream is ready; a literal flush holds the input while
// the back end drains the literal buffer RAM through its read port.
// Reset: asynchronous, active low; clears all control state, the RAM is not cleared.
module rle_packet_encoder_core #(
  parameter int unsigned MAX_LEN = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  rpe_stream_if.sink   in_i,
  rpe_stream_if.source out_o
);
  localparam int unsigned IdxW     = $clog2(MAX_LEN);
  localparam int unsigned AddrW    = IdxW + 1;
  // two banks of literal storage so the next packet's first byte can be stored while the old waits
  localparam int unsigned RamDepth = 2 ** AddrW;

  // front -> queue
  logic              cmd_push;
  rpe_pkg::pkt_cmd_t cmd_in;
  logic              fifo_full;
  // queue -> back
  logic              cmd_valid;
  rpe_pkg::pkt_cmd_t cmd_head;
  logic              cmd_pop;
  logic              lit_done;
  // literal buffer
  logic              ram_we, ram_re;
  logic [AddrW-1:0]  ram_waddr, ram_raddr;
  logic [7:0]        ram_wdata, ram_rdata;
  // output
  logic               out_valid;
  rpe_pkg::out_item_t out_item;

  // Front: classifies each byte against the pending one, stores literals,
  // and queues at most two packet commands per transaction.
  rpe_front #(
    .MAX_LEN (MAX_LEN)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .in_item_i   (in_i.payload),
    .push_o      (cmd_push),
    .push_cmd_o  (cmd_in),
    .fifo_full_i (fifo_full),
    .lit_done_i  (lit_done),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata)
  );

  rpe_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .cmd_i   (cmd_in),
    .full_o  (fifo_full),
    .pop_i   (cmd_pop),
    .valid_o (cmd_valid),
    .cmd_o   (cmd_head)
  );

  rpe_ram #(
    .WIDTH (8),
    .DEPTH (RamDepth)
  ) u_lit_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Back: header, buffered literals, trailing byte; the output register holds each
  // byte for the downstream, whose ready still gates the queue pop directly.
  rpe_back #(
    .MAX_LEN (MAX_LEN)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd_head),
    .pop_o       (cmd_pop),
    .lit_done_o  (lit_done),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .out_item_o  (out_item)
  );

  assign out_o.valid   = out_valid;
  assign out_o.payload = out_item;

`ifndef SYNTHESIS
  // literals are only written while no literal packet is being read out
  a_ram_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("literal RAM written while a literal packet is read");

  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_push |-> !fifo_full)
    else $error("packet command pushed into a full queue");

  a_hdr_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.payload.is_header |->
      (out_o.payload.out_byte[6:0] < 7'(MAX_LEN)))
    else $error("packet header count beyond the packet limit");
`endif
endmodule

FILE: src/rpe_ram.sv
// rpe_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module rpe_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

FILE: src/rpe_cmd_fifo.sv
// rpe_cmd_fifo: short queue of packet commands between front and back.
// Depends on rpe_pkg (pkt_cmd_t, CMD_DEPTH).
module rpe_cmd_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  rpe_pkg::pkt_cmd_t cmd_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output rpe_pkg::pkt_cmd_t cmd_o
);
  localparam int unsigned PtrW = $clog2(rpe_pkg::CMD_DEPTH);

  rpe_pkg::pkt_cmd_t mem_q [rpe_pkg::CMD_DEPTH];
  logic [PtrW-1:0]   wptr_q, wptr_d;
  logic [PtrW-1:0]   rptr_q, rptr_d;
  logic [PtrW:0]     count_q, count_d;
  logic              do_push, do_pop;

  assign full_o  = (count_q == (PtrW+1)'(rpe_pkg::CMD_DEPTH));
  assign valid_o = (count_q != '0);
  assign cmd_o   = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wptr_d  = do_push ? wptr_q + PtrW'(1) : wptr_q;
    rptr_d  = do_pop ? rptr_q + PtrW'(1) : rptr_q;
    count_d = count_q + (PtrW+1)'(do_push) - (PtrW+1)'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end
endmodule

FILE: src/rpe_front.sv
// rpe_front: accepts input bytes, tracks run/literal state, writes literals
// to the buffer RAM and queues packet commands. Depends on rpe_pkg.
module rpe_front #(
  parameter int unsigned MAX_LEN = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  rpe_pkg::in_item_t          in_item_i,
  output logic                       push_o,
  output rpe_pkg::pkt_cmd_t          push_cmd_o,
  input  logic                       fifo_full_i,
  input  logic                       lit_done_i,
  output logic                       ram_we_o,
  output logic [$clog2(MAX_LEN):0]   ram_waddr_o,
  output logic [7:0]                 ram_wdata_o
);
  localparam int unsigned IdxW = $clog2(MAX_LEN);

  function automatic rpe_pkg::pkt_cmd_t run_cmd(input logic [IdxW-1:0] len_m1,
                                                input logic [7:0] value);
    rpe_pkg::pkt_cmd_t c;
    c      = '0;
    c.hdr  = rpe_pkg::RUN_FLAG | 8'(len_m1);
    c.tail = 1'b1;
    c.data = value;
    return c;
  endfunction

  function automatic rpe_pkg::pkt_cmd_t lit_cmd(input logic [IdxW-1:0] nbuf,
                                                input logic tail,
                                                input logic [7:0] value,
                                                input logic bank);
    rpe_pkg::pkt_cmd_t c;
    c      = '0;
    // header = total bytes - 1; a trailing byte adds one
    c.hdr  = tail ? 8'(nbuf) : 8'(nbuf) - 8'd1;
    c.nbuf = rpe_pkg::CNT_BITS'(nbuf);
    c.tail = tail;
    c.data = value;
    c.bank = bank;
    c.lit  = 1'b1;
    return c;
  endfunction

  logic [7:0]        pend_q, pend_d;
  logic              have_q, have_d;
  logic [IdxW-1:0]   cnt_q, cnt_d;
  logic              run_q, run_d;
  logic              bank_q, bank_d;
  logic [1:0]        lit_out_q, lit_out_d;
  logic              hold_valid_q, hold_valid_d;
  rpe_pkg::pkt_cmd_t hold_cmd_q, hold_cmd_d;

  logic              accept;
  logic              full_pkt;
  logic [7:0]        b;
  logic              last;
  logic              c1_v, c2_v;
  rpe_pkg::pkt_cmd_t c1, c2;
  logic [IdxW-1:0]   cnt_n;
  logic              run_n, bank_n;
  logic [1:0]        lit_inc;

  // Next item waits for the queue, for a pending second command, and for
  // every queued literal packet to drain (the back still reads the buffer).
  assign in_ready_o = !hold_valid_q && !fifo_full_i && (lit_out_q == 2'd0);
  assign accept     = in_valid_i && in_ready_o;
  assign b          = in_item_i.in_byte;
  assign last       = in_item_i.end_of_stream;
  assign full_pkt   = (32'(cnt_q) >= MAX_LEN - 1);

  always_comb begin
    c1_v        = 1'b0;
    c2_v        = 1'b0;
    c1          = '0;
    c2          = '0;
    cnt_n       = cnt_q;
    run_n       = run_q;
    bank_n      = bank_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = {bank_q, cnt_q};
    ram_wdata_o = pend_q;

    if (have_q) begin
      if (full_pkt) begin
        c1_v = 1'b1;
        if (run_q) begin
          c1    = run_cmd(cnt_q, pend_q);
          run_n = 1'b0;
          cnt_n = '0;
        end else begin
          // full literal: pending byte opens the next packet in the other bank
          c1          = lit_cmd(cnt_q, 1'b0, 8'd0, bank_q);
          bank_n      = ~bank_q;
          ram_we_o    = accept;
          ram_waddr_o = {~bank_q, {IdxW{1'b0}}};
          cnt_n       = IdxW'(1);
        end
      end else if (b == pend_q) begin
        if (!run_q && (cnt_q != '0)) begin
          c1_v   = 1'b1;
          c1     = lit_cmd(cnt_q, 1'b0, 8'd0, bank_q);
          bank_n = ~bank_q;
          cnt_n  = IdxW'(1);
        end else begin
          cnt_n = cnt_q + IdxW'(1);
        end
        run_n = 1'b1;
      end else if (run_q) begin
        c1_v  = 1'b1;
        c1    = run_cmd(cnt_q, pend_q);
        run_n = 1'b0;
        cnt_n = '0;
      end else begin
        ram_we_o = accept;
        cnt_n    = cnt_q + IdxW'(1);
      end
    end

    // end of stream flushes the open packet, incoming byte last
    if (last) begin
      c2_v = 1'b1;
      c2   = run_n ? run_cmd(cnt_n, b) : lit_cmd(cnt_n, 1'b1, b, bank_n);
    end
    c1.last = !last;
    c2.last = 1'b1;
  end

  always_comb begin
    lit_inc      = 2'(c1_v && c1.lit) + 2'(c2_v && c2.lit);
    lit_out_d    = lit_out_q + (accept ? lit_inc : 2'd0) - 2'(lit_done_i);
    hold_valid_d = hold_valid_q;
    hold_cmd_d   = hold_cmd_q;
    push_o       = 1'b0;
    push_cmd_o   = c1_v ? c1 : c2;
    if (hold_valid_q) begin
      push_o     = !fifo_full_i;
      push_cmd_o = hold_cmd_q;
      if (!fifo_full_i) begin
        hold_valid_d = 1'b0;
      end
    end else if (accept) begin
      push_o       = c1_v || c2_v;
      hold_valid_d = c1_v && c2_v;
      hold_cmd_d   = c2;
    end

    pend_d = pend_q;
    have_d = have_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    bank_d = bank_q;
    if (accept) begin
      bank_d = bank_n;
      if (last) begin
        pend_d = '0;
        have_d = 1'b0;
        cnt_d  = '0;
        run_d  = 1'b0;
      end else begin
        pend_d = b;
        have_d = 1'b1;
        cnt_d  = cnt_n;
        run_d  = run_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q       <= '0;
      have_q       <= 1'b0;
      cnt_q        <= '0;
      run_q        <= 1'b0;
      bank_q       <= 1'b0;
      lit_out_q    <= '0;
      hold_valid_q <= 1'b0;
    end else begin
      pend_q       <= pend_d;
      have_q       <= have_d;
      cnt_q        <= cnt_d;
      run_q        <= run_d;
      bank_q       <= bank_d;
      lit_out_q    <= lit_out_d;
      hold_valid_q <= hold_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_cmd_q <= hold_cmd_d;
  end
endmodule

FILE: src/rpe_back.sv
// rpe_back: executes packet commands, one output byte per cycle while a command waits and the output
// register can advance, reading literals from the buffer RAM. Depends on rpe_pkg.
module rpe_back #(
  parameter int unsigned MAX_LEN = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cmd_valid_i,
  input  rpe_pkg::pkt_cmd_t        cmd_i,
  output logic                     pop_o,
  output logic                     lit_done_o,
  output logic                     ram_re_o,
  output logic [$clog2(MAX_LEN):0] ram_raddr_o,
  input  logic [7:0]               ram_rdata_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output rpe_pkg::out_item_t       out_item_o
);
  localparam int unsigned IdxW = $clog2(MAX_LEN);

  typedef enum logic [2:0] {
    BK_HDR  = 3'b001,
    BK_BUF  = 3'b010,
    BK_TAIL = 3'b100
  } back_state_e;

  back_state_e        state_q, state_d;
  logic [IdxW-1:0]    idx_q, idx_d;
  logic               out_valid_q, out_valid_d;
  rpe_pkg::out_item_t out_item_q;
  rpe_pkg::out_item_t item;
  logic               can_push, push;

  assign can_push = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    push        = 1'b0;
    pop_o       = 1'b0;
    item        = '0;
    ram_re_o    = 1'b0;
    ram_raddr_o = {cmd_i.bank, idx_q};
    case (state_q)
      BK_HDR: begin
        if (cmd_valid_i && can_push) begin
          push           = 1'b1;
          item.out_byte  = cmd_i.hdr;
          item.is_header = 1'b1;
          if (cmd_i.nbuf != '0) begin
            ram_re_o    = 1'b1;
            ram_raddr_o = {cmd_i.bank, {IdxW{1'b0}}};
            idx_d       = IdxW'(1);
            state_d     = BK_BUF;
          end else if (cmd_i.tail) begin
            state_d = BK_TAIL;
          end else begin
            pop_o             = 1'b1;
            item.last_of_item = cmd_i.last;
          end
        end
      end
      BK_BUF: begin
        if (can_push) begin
          push          = 1'b1;
          item.out_byte = ram_rdata_i;
          if (rpe_pkg::CNT_BITS'(idx_q) != cmd_i.nbuf) begin
            // prefetch the next literal; read data is ready next cycle
            ram_re_o = 1'b1;
            idx_d    = idx_q + IdxW'(1);
          end else if (cmd_i.tail) begin
            state_d = BK_TAIL;
          end else begin
            pop_o             = 1'b1;
            item.last_of_item = cmd_i.last;
            state_d           = BK_HDR;
          end
        end
      end
      BK_TAIL: begin
        if (can_push) begin
          push              = 1'b1;
          item.out_byte     = cmd_i.data;
          item.last_of_item = cmd_i.last;
          pop_o             = 1'b1;
          state_d           = BK_HDR;
        end
      end
      default: begin
        state_d = BK_HDR;
      end
    endcase
    out_valid_d = push || (out_valid_q && !out_ready_i);
  end

  assign lit_done_o  = pop_o && cmd_i.lit;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_HDR;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      out_item_q <= item;
    end
  end
endmodule

FILE: verif/tb_rle_packet_encoder_core.sv
`timescale 1ns / 100ps
// tb_rle_packet_encoder_core: self-checking bench for the run-length packet encoder.
// Depends on rpe_pkg, rpe_stream_if and rle_packet_encoder_core; a scoreboard
// fed by a behavioral encoder and inline expected bytes checks every output byte of directed and random streams.
module tb_rle_packet_encoder_core;

  localparam int unsigned MAX_LEN      = 32;
  localparam int unsigned BURST_MAX    = 13;   // longest random idle burst, either side
  localparam int unsigned LONG_HOLD    = 300;  // sink hold-off used to back up the block
  localparam int unsigned DRAIN_CYCLES = 40;   // quiet cycles after the last byte
  localparam int unsigned RAND_ITEMS   = 90;
  localparam int unsigned HOLD_AT      = 5;    // random item count that triggers the hold-off
  localparam int unsigned HOLD_ITEMS   = 40;   // literal bytes sent from the start of the hold-off
  localparam int unsigned PAUSE_AT     = 45;   // random item count for the drain pause
  localparam int unsigned QUIET_FROM   = 70;   // no idling from here to the end
  localparam int unsigned MAX_PRINTS   = 50;
  localparam longint      TIMEOUT_NS   = 64'd10_000_000;

  // One directed row: reps bytes starting at val, stepping by stride. The
  // stream-end flag goes on the last byte only. Typed rows carry their
  // expected bytes inline; the others are checked against the encoder model.
  typedef struct packed {
    logic [7:0]         val;
    logic               eos;
    logic [7:0]         reps;
    logic [7:0]         stride;
    logic               typed;
    logic [1:0]         n_fixed;
    rpe_pkg::out_item_t f0;
    rpe_pkg::out_item_t f1;
  } dir_row_t;

  localparam int unsigned N_DIR = 15;
  localparam dir_row_t DIR_TBL [N_DIR] = '{
    // lone zero byte right after reset: one-byte literal packet
    '{8'h00, 1'b1, 8'd1, 8'd0, 1'b1, 2'd2, '{8'h00, 1'b1, 1'b0}, '{8'h00, 1'b0, 1'b1}},
    // lone 0xFF
    '{8'hFF, 1'b1, 8'd1, 8'd0, 1'b1, 2'd2, '{8'h00, 1'b1, 1'b0}, '{8'hFF, 1'b0, 1'b1}},
    // first byte of a stream only becomes pending
    '{8'hAB, 1'b0, 8'd1, 8'd0, 1'b1, 2'd0, '0, '0},
    // repeat closes the stream: two-byte run
    '{8'hAB, 1'b1, 8'd1, 8'd0, 1'b1, 2'd2, '{8'h81, 1'b1, 1'b0}, '{8'hAB, 1'b0, 1'b1}},
    // literals, then literal-to-run, run-to-literal, end
    '{8'h01, 1'b0, 8'd3, 8'd1, 1'b0, 2'd0, '0, '0},
    '{8'h03, 1'b0, 8'd2, 8'd0, 1'b0, 2'd0, '0, '0},
    '{8'h7F, 1'b0, 8'd1, 8'd0, 1'b0, 2'd0, '0, '0},
    '{8'h80, 1'b1, 8'd1, 8'd0, 1'b0, 2'd0, '0, '0},
    // run past the packet limit: full run flush, next byte only pends
    '{8'h55, 1'b0, 8'd33, 8'd0, 1'b0, 2'd0, '0, '0},
    '{8'h56, 1'b1, 8'd1, 8'd0, 1'b0, 2'd0, '0, '0},
    // literals past the limit: pending byte becomes first literal of the next packet
    '{8'h00, 1'b0, 8'd33, 8'd1, 1'b0, 2'd0, '0, '0},
    '{8'h40, 1'b0, 8'd2, 8'd0, 1'b0, 2'd0, '0, '0},
    '{8'h41, 1'b1, 8'd1, 8'd0, 1'b0, 2'd0, '0, '0},
    // run of exactly the limit closed by end of stream
    '{8'hA5, 1'b1, 8'd32, 8'd0, 1'b0, 2'd0, '0, '0},
    // literal packet of exactly the limit closed by end of stream
    '{8'hC0, 1'b1, 8'd32, 8'd1, 1'b0, 2'd0, '0, '0}
  };

  logic clk_i;
  logic rst_ni;

  rpe_stream_if #(.payload_t(rpe_pkg::in_item_t))  in_if ();
  rpe_stream_if #(.payload_t(rpe_pkg::out_item_t)) out_if ();

  rle_packet_encoder_core #(
    .MAX_LEN(MAX_LEN)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // ---------------------------------------------------------------------------
  // Encoder model state. Bytes the block owes are queued in encoded_due at
  // the edge where the input transaction is accepted.
  // ---------------------------------------------------------------------------
  logic [7:0]         enc_pend;
  logic               enc_have;
  int unsigned        enc_cnt;      // run: length-1; literal: bytes buffered
  logic               enc_run;
  logic [7:0]         enc_lits [MAX_LEN];
  rpe_pkg::out_item_t step_bytes [$];
  rpe_pkg::out_item_t encoded_due [$];

  int unsigned err_cnt   = 0;
  int unsigned rand_sent = 0;
  logic        idle_on   = 1'b1;
  logic        hold_req  = 1'b0;
  rpe_pkg::out_item_t mon_want;

  function automatic void put_byte(input logic [7:0] b, input logic hdr);
    rpe_pkg::out_item_t o;
    o.out_byte     = b;
    o.is_header    = hdr;
    o.last_of_item = 1'b0;
    step_bytes.push_back(o);
  endfunction

  function automatic void put_run(input int unsigned cnt_m1, input logic [7:0] b);
    put_byte(rpe_pkg::RUN_FLAG | (8'(cnt_m1) & 8'h7F), 1'b1);
    put_byte(b, 1'b0);
  endfunction

  function automatic void put_literal(input int unsigned nbytes);
    put_byte(8'(nbytes - 1) & 8'h7F, 1'b1);
    for (int unsigned i = 0; i < nbytes; i++) begin
      put_byte(enc_lits[i], 1'b0);
    end
  endfunction

  function automatic void enc_reset();
    enc_pend = 8'h00;
    enc_have = 1'b0;
    enc_cnt  = 0;
    enc_run  = 1'b0;
  endfunction

  // Works out the packet bytes caused by one input byte into step_bytes.
  function automatic void rle_encode_step(input logic [7:0] b, input logic eos);
    step_bytes.delete();
    if (enc_have) begin
      if (enc_cnt >= MAX_LEN - 1) begin
        // full packet: flush without comparing the incoming byte
        if (enc_run) begin
          put_run(enc_cnt, enc_pend);
          enc_run = 1'b0;
          enc_cnt = 0;
        end else begin
          put_literal(enc_cnt);
          enc_lits[0] = enc_pend;
          enc_cnt     = 1;
        end
      end else if (b == enc_pend) begin
        if (!enc_run && enc_cnt > 0) begin
          put_literal(enc_cnt);
          enc_cnt = 0;
        end
        enc_cnt++;
        enc_run = 1'b1;
      end else if (enc_run) begin
        put_run(enc_cnt, enc_pend);
        enc_run = 1'b0;
        enc_cnt = 0;
      end else begin
        enc_lits[enc_cnt] = enc_pend;
        enc_cnt++;
      end
    end
    enc_pend = b;
    enc_have = 1'b1;
    if (eos) begin
      if (enc_run) begin
        put_run(enc_cnt, enc_pend);
      end else begin
        enc_lits[enc_cnt] = enc_pend;
        put_literal(enc_cnt + 1);
      end
      enc_reset();
    end
    if (step_bytes.size() > 0) begin
      step_bytes[step_bytes.size() - 1].last_of_item = 1'b1;
    end
  endfunction

  task automatic flag_mismatch(input string what);
    err_cnt++;
    if (err_cnt <= MAX_PRINTS) begin
      $display("%0t ns: mismatch: %s", $time, what);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Source side. Valid may drop for a random burst before a byte; a byte is
  // committed to the model at the edge where the transaction completes.
  // ---------------------------------------------------------------------------
  task automatic offer_byte(input logic [7:0] b, input logic eos, input logic use_model);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, BURST_MAX)) @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.payload <= '{in_byte: b, end_of_stream: eos};
    do @(posedge clk_i); while (!in_if.ready);
    rle_encode_step(b, eos);
    if (use_model) begin
      foreach (step_bytes[i]) encoded_due.push_back(step_bytes[i]);
    end
  endtask

  // Valid goes low, then the source waits for the block to deliver everything it owes.
  task automatic pause_for_drain();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (encoded_due.size() != 0);
  endtask

  // Random stream: runs, distinct literals and small-alphabet noise, with
  // occasional long segments to cross the packet limit. End flag on the last byte.
  task automatic send_random_stream(input int unsigned len, input logic lit_only);
    int unsigned left;
    int unsigned seg;
    int unsigned mode;
    int unsigned k;
    logic [7:0]  v;
    left = len;
    v    = 8'($urandom);
    while (left > 0) begin
      mode = lit_only ? 5 : $urandom_range(0, 9);
      seg  = ($urandom_range(0, 7) == 0) ? $urandom_range(28, 40) : $urandom_range(1, 6);
      if (seg > left) seg = left;
      if (mode < 4) v = 8'($urandom);
      for (k = 0; k < seg; k++) begin
        if (mode >= 4 && mode < 8) begin
          v = v + 8'($urandom_range(1, 255));
        end else if (mode >= 8) begin
          v = 8'($urandom_range(0, 3));
        end
        offer_byte(v, left == 1, 1'b1);
        left--;
        rand_sent++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sink side: random not-ready bursts, plus one long hold-off on request.
  // ---------------------------------------------------------------------------
  initial begin
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        hold_req = 1'b0;
        out_if.ready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, BURST_MAX)) @(posedge clk_i);
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Scoreboard: every output transaction against the oldest owed byte.
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (encoded_due.size() == 0) begin
        flag_mismatch($sformatf("unexpected byte %02h hdr=%0b last=%0b",
                                out_if.payload.out_byte, out_if.payload.is_header,
                                out_if.payload.last_of_item));
      end else begin
        mon_want = encoded_due.pop_front();
        if (out_if.payload.out_byte !== mon_want.out_byte)
          flag_mismatch($sformatf("out_byte %02h, want %02h",
                                  out_if.payload.out_byte, mon_want.out_byte));
        if (out_if.payload.is_header !== mon_want.is_header)
          flag_mismatch($sformatf("is_header %0b, want %0b (byte %02h)",
                                  out_if.payload.is_header, mon_want.is_header,
                                  mon_want.out_byte));
        if (out_if.payload.last_of_item !== mon_want.last_of_item)
          flag_mismatch($sformatf("last_of_item %0b, want %0b (byte %02h)",
                                  out_if.payload.last_of_item, mon_want.last_of_item,
                                  mon_want.out_byte));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence: reset, directed table, random streams, drain, verdict.
  // ---------------------------------------------------------------------------
  initial begin
    dir_row_t    row;
    int unsigned r;
    int unsigned len;
    logic        hold_done;
    logic        pause_done;
    hold_done  = 1'b0;
    pause_done = 1'b0;
    enc_reset();
    in_if.valid   <= 1'b0;
    in_if.payload <= '0;
    rst_ni        <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int unsigned k = 0; k < N_DIR; k++) begin
      row = DIR_TBL[k];
      for (r = 0; r < row.reps; r++) begin
        offer_byte(8'(row.val + row.stride * r), row.eos && (r == row.reps - 1), !row.typed);
      end
      if (row.typed && row.n_fixed > 0) encoded_due.push_back(row.f0);
      if (row.typed && row.n_fixed > 1) encoded_due.push_back(row.f1);
    end
    pause_for_drain();

    while (rand_sent < RAND_ITEMS) begin
      if (rand_sent >= QUIET_FROM) idle_on = 1'b0;
      if (!hold_done && rand_sent >= HOLD_AT) begin
        // long literal stream while the sink is held off: the block backs up
        hold_done = 1'b1;
        hold_req  = 1'b1;
        send_random_stream(HOLD_ITEMS, 1'b1);
      end else if (!pause_done && rand_sent >= PAUSE_AT) begin
        pause_done = 1'b1;
        pause_for_drain();
      end else begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 80) : $urandom_range(1, 40);
        if (len > RAND_ITEMS - rand_sent) len = RAND_ITEMS - rand_sent;
        send_random_stream(len, 1'b0);
      end
    end

    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (encoded_due.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("[rle_packet_encoder_core] OK");
    end else begin
      $display("[rle_packet_encoder_core] ERROR");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("timeout with %0d bytes still owed", encoded_due.size());
    $display("[rle_packet_encoder_core] ERROR");
    $finish;
  end

endmodule
